@@ hdl/sbc_pkg.sv @@
// shared types, constants, s-box tables and round functions of the serpent block cipher unit
package sbc_pkg;

   // command codes
   localparam logic [1:0] CMD_WRITE_KEY = 2'd0;
   localparam logic [1:0] CMD_EXPAND    = 2'd1;
   localparam logic [1:0] CMD_WRITE_RK  = 2'd2;
   localparam logic [1:0] CMD_BLOCK     = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNKEYED = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ENCRYPT_MODE  = 2'd0;
   localparam logic [1:0] CSR_KEY_BYTES     = 2'd1;
   localparam logic [1:0] CSR_LOADED_ROUNDS = 2'd2;

   localparam logic [31:0] GOLDEN  = 32'h9E37_79B9;
   localparam int          KEY_ROT = 11;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [8:0]  word_index;
      logic [31:0] key_word;
      logic [63:0] block_low;
      logic [63:0] block_high;
   } req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_MIX,
      OP_ENC,
      OP_DEC,
      OP_SBOX
   } round_op_type;

   typedef struct packed {
      round_op_type op;
      logic [2:0]   sbox_sel;
      logic         skip_lin;
   } round_ctrl_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic gen;
      logic wide;
   } win_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXP_LOAD,
      ST_EXP_GEN,
      ST_BLK_RUN
   } state_type;

   localparam logic [3:0] SBOX_FWD [8][16] = '{
      '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
        4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
      '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
        4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
      '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
        4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
      '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
        4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
      '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
        4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
      '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
        4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
      '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
        4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
      '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
        4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
   };

   localparam logic [3:0] SBOX_INV [8][16] = '{
      '{4'd13, 4'd3, 4'd11, 4'd0, 4'd10, 4'd6, 4'd5, 4'd12,
        4'd1, 4'd14, 4'd4, 4'd7, 4'd15, 4'd9, 4'd8, 4'd2},
      '{4'd5, 4'd8, 4'd2, 4'd14, 4'd15, 4'd6, 4'd12, 4'd3,
        4'd11, 4'd4, 4'd7, 4'd9, 4'd1, 4'd13, 4'd10, 4'd0},
      '{4'd12, 4'd9, 4'd15, 4'd4, 4'd11, 4'd14, 4'd1, 4'd2,
        4'd0, 4'd3, 4'd6, 4'd13, 4'd5, 4'd8, 4'd10, 4'd7},
      '{4'd0, 4'd9, 4'd10, 4'd7, 4'd11, 4'd14, 4'd6, 4'd13,
        4'd3, 4'd5, 4'd12, 4'd2, 4'd4, 4'd8, 4'd15, 4'd1},
      '{4'd5, 4'd0, 4'd8, 4'd3, 4'd10, 4'd9, 4'd7, 4'd14,
        4'd2, 4'd12, 4'd11, 4'd6, 4'd4, 4'd15, 4'd13, 4'd1},
      '{4'd8, 4'd15, 4'd2, 4'd9, 4'd4, 4'd1, 4'd13, 4'd14,
        4'd11, 4'd6, 4'd5, 4'd3, 4'd7, 4'd12, 4'd10, 4'd0},
      '{4'd15, 4'd10, 4'd1, 4'd13, 4'd5, 4'd3, 4'd6, 4'd0,
        4'd4, 4'd9, 4'd14, 4'd7, 4'd2, 4'd12, 4'd8, 4'd11},
      '{4'd3, 4'd0, 4'd6, 4'd13, 4'd9, 4'd14, 4'd15, 4'd8,
        4'd5, 4'd12, 4'd11, 4'd7, 4'd10, 4'd1, 4'd4, 4'd2}
   };

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // bitsliced s-box over the 32 columns of four words
   function automatic logic [127:0] sbox_apply(input logic [127:0] x, input logic [2:0] sel,
                                               input logic inverse);
      logic [127:0] y;
      logic [3:0]   nib;
      logic [3:0]   o;
      y = '0;
      for (int j = 0; j < 32; j++) begin
         nib = {x[96+j], x[64+j], x[32+j], x[j]};
         o = inverse ? SBOX_INV[sel][nib] : SBOX_FWD[sel][nib];
         y[j]    = o[0];
         y[32+j] = o[1];
         y[64+j] = o[2];
         y[96+j] = o[3];
      end
      return y;
   endfunction

   function automatic logic [127:0] lin_fwd(input logic [127:0] x);
      logic [31:0] a, b, c, d;
      a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
      a = rotl32(a, 13); c = rotl32(c, 3);
      b = b ^ a ^ c; d = d ^ c ^ (a << 3);
      b = rotl32(b, 1); d = rotl32(d, 7);
      a = a ^ b ^ d; c = c ^ d ^ (b << 7);
      a = rotl32(a, 5); c = rotl32(c, 22);
      return {d, c, b, a};
   endfunction

   function automatic logic [127:0] lin_inv(input logic [127:0] x);
      logic [31:0] a, b, c, d;
      a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
      c = rotl32(c, 10); a = rotl32(a, 27);
      c = c ^ d ^ (b << 7); a = a ^ b ^ d;
      d = rotl32(d, 25); b = rotl32(b, 31);
      d = d ^ c ^ (a << 3); b = b ^ a ^ c;
      c = rotl32(c, 29); a = rotl32(a, 19);
      return {d, c, b, a};
   endfunction

endpackage

@@ hdl/sbc_round_unit.sv @@
// shared round unit: key mix, s-box layer and linear transform
module sbc_round_unit (
   input  sbc_pkg::round_ctrl_type ctrl,
   input  logic [127:0]            state_in,
   input  logic [127:0]            round_key,
   output logic [127:0]            state_out
);

   logic [127:0] mid;

   always_comb begin
      mid = '0;
      state_out = state_in;
      unique case (ctrl.op)
         sbc_pkg::OP_MIX: begin
            state_out = state_in ^ round_key;
         end
         sbc_pkg::OP_ENC: begin
            mid = sbc_pkg::sbox_apply(state_in ^ round_key, ctrl.sbox_sel, 1'b0);
            state_out = ctrl.skip_lin ? mid : sbc_pkg::lin_fwd(mid);
         end
         sbc_pkg::OP_DEC: begin
            mid = sbc_pkg::sbox_apply(state_in, ctrl.sbox_sel, 1'b1) ^ round_key;
            state_out = ctrl.skip_lin ? mid : sbc_pkg::lin_inv(mid);
         end
         sbc_pkg::OP_SBOX: begin
            state_out = sbc_pkg::sbox_apply(state_in, ctrl.sbox_sel, 1'b0);
         end
         default: state_out = state_in;
      endcase
   end

endmodule

@@ hdl/sbc_rk_ram.sv @@
// round key memory: four word banks, one 128-bit row read per cycle
module sbc_rk_ram #(
   parameter int ROWS = 65
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [$clog2(ROWS)-1:0] wr_row,
   input  logic [3:0]              wr_mask,
   input  logic [127:0]            wr_data,
   input  logic [$clog2(ROWS)-1:0] rd_row,
   output logic [127:0]            rd_data
);

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [31:0] mem [ROWS];
      logic [31:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en && wr_mask[b]) begin
            mem[wr_row] <= wr_data[32*b +: 32];
         end
         rd_ff <= mem[rd_row];
      end

      assign rd_data[32*b +: 32] = rd_ff;
   end

endmodule

@@ hdl/sbc_key_window.sv @@
// sliding prekey window and phi recurrence of the key schedule
module sbc_key_window (
   input  logic                  clock,
   input  sbc_pkg::win_ctrl_type ctrl,
   input  logic [31:0]           load_word,
   input  logic [7:0]            gen_index,
   output logic [127:0]          group
);

   logic [31:0] win_ff [16];
   logic [31:0] tap_sum;
   logic [31:0] new_word;

   always_comb begin
      tap_sum = win_ff[8] ^ win_ff[11] ^ win_ff[13] ^ win_ff[15] ^ sbc_pkg::GOLDEN
                ^ {24'd0, gen_index};
      if (ctrl.wide) begin
         tap_sum = tap_sum ^ win_ff[0] ^ win_ff[3] ^ win_ff[5] ^ win_ff[6];
      end
      new_word = sbc_pkg::rotl32(tap_sum, sbc_pkg::KEY_ROT);
   end

   // newest word is the top of the group
   assign group = {new_word, win_ff[15], win_ff[14], win_ff[13]};

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         for (int k = 0; k < 16; k++) win_ff[k] <= '0;
      end else if (ctrl.load || ctrl.gen) begin
         for (int k = 0; k < 15; k++) win_ff[k] <= win_ff[k+1];
         win_ff[15] <= ctrl.load ? load_word : new_word;
      end
   end

endmodule

@@ hdl/serpent_block_cipher_unit.sv @@
// top level of the serpent block cipher unit: command handling, sequencer and result register
//
// usage
//   req_* carries one command beat: write user key word, expand key, write round key
//   word or process a block. every command yields exactly one rsp_* beat carrying the
//   output block (zero unless a good block command) and a status code.
//   csr_* writes encrypt_mode, key_bytes and loaded_rounds; it is always ready. it is to be
//   written only while the unit is idle; the unit itself does not enforce this.
// sequencing and throughput
//   key and round key word writes, and rejected commands, answer in the cycle after the
//   beat is taken. a block makes one pass through the shared round unit per cycle,
//   paced by the round key memory giving one 128-bit row a cycle. key expansion first
//   loads the prekey window, then generates one schedule word a cycle.
//   only one command is in flight; req_ready is low while it works.
// reset
//   synchronous; clears the sequencer, the user key words and the keyed flag and sets
//   the registers to their defaults. round keys are undefined until written.
// stalls
//   the result sits in an output register until rsp_ready; a new command is taken only
//   when that register is empty or draining in the same cycle.
module serpent_block_cipher_unit #(
   parameter int MAX_ROUND_KEY_WORDS = 260,
   parameter int KEY_WORDS           = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sbc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [6:0]       csr_data
);

   localparam int ROWS  = (MAX_ROUND_KEY_WORDS + 3) / 4;
   localparam int ROW_W = $clog2(ROWS);
   localparam int UK_W  = $clog2(KEY_WORDS);

   // state and registers
   sbc_pkg::state_type state_ff, state_in;
   logic [7:0]   step_ff, step_in;
   logic         mode_ff;
   logic [6:0]   key_bytes_ff;
   logic [6:0]   loaded_rounds_ff;
   logic [31:0]  user_key_ff [KEY_WORDS];
   logic [6:0]   round_count_ff, round_count_in;
   logic         keyed_ff, keyed_in;
   logic [127:0] blk_ff, blk_in;
   logic         rsp_valid_ff, rsp_valid_in;
   sbc_pkg::rsp_type rsp_ff, rsp_in;

   // datapath controls
   logic                   req_fire;
   logic                   rsp_load;
   logic                   uk_wr;
   logic                   ram_wr_en;
   logic [ROW_W-1:0]       ram_wr_row;
   logic [3:0]             ram_wr_mask;
   logic [127:0]           ram_wr_data;
   logic [ROW_W-1:0]       ram_rd_row;
   logic [127:0]           ram_rd_data;
   sbc_pkg::round_ctrl_type rctrl;
   logic [127:0]           ru_out;
   logic [127:0]           ru_in;
   sbc_pkg::win_ctrl_type  wctrl;
   logic [31:0]            ext_word;
   logic [127:0]           win_group;

   // decoded checks
   logic       len_ok;
   logic       exp_ok;
   logic       wide;
   logic [4:0] nw;
   logic [4:0] uk_sel;
   logic [7:0] load_last;
   logic [7:0] gen_last;
   logic       rk_cfg_ok;
   logic [9:0] rk_need;
   logic [7:0] rev_step;
   logic [7:0] rev_next;
   logic [7:0] next_step;
   logic       blk_last;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == sbc_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // key length check: 16, 24, 32 or 64 bytes, within the stores
   assign wide      = (key_bytes_ff == 7'd64);
   assign nw        = key_bytes_ff[6:2];
   assign len_ok    = (key_bytes_ff == 7'd16) || (key_bytes_ff == 7'd24) ||
                      (key_bytes_ff == 7'd32) || wide;
   assign exp_ok    = len_ok && (nw <= 5'(KEY_WORDS)) &&
                      ((wide ? 10'd164 : 10'd132) <= 10'(MAX_ROUND_KEY_WORDS));
   assign load_last = wide ? 8'd15 : 8'd7;
   assign gen_last  = wide ? 8'd163 : 8'd131;

   // loaded round count: multiple of 8 in 32..64 with room for all its keys
   assign rk_need   = ({3'd0, loaded_rounds_ff} + 10'd1) << 2;
   assign rk_cfg_ok = (loaded_rounds_ff >= 7'd32) && (loaded_rounds_ff <= 7'd64) &&
                      (loaded_rounds_ff[2:0] == 3'd0) &&
                      (rk_need <= 10'(MAX_ROUND_KEY_WORDS));

   // prekey word: user key in reverse word order, then a single one, then zeros
   assign uk_sel = nw - 5'd1 - step_ff[4:0];
   always_comb begin
      if (step_ff[4:0] < nw) begin
         ext_word = user_key_ff[uk_sel[UK_W-1:0]];
      end else if (step_ff[4:0] == nw) begin
         ext_word = 32'd1;
      end else begin
         ext_word = 32'd0;
      end
   end

   // block round position: decryption walks the keys downwards
   assign rev_step  = {1'b0, round_count_ff} - step_ff;
   assign rev_next  = rev_step - 8'd1;
   assign next_step = step_ff + 8'd1;
   assign blk_last  = (step_ff == {1'b0, round_count_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == sbc_pkg::CMD_EXPAND && exp_ok) begin
                  state_in = sbc_pkg::ST_EXP_LOAD;
               end else if (req_data.cmd == sbc_pkg::CMD_BLOCK && keyed_ff) begin
                  state_in = sbc_pkg::ST_BLK_RUN;
               end
            end
         end
         sbc_pkg::ST_EXP_LOAD: begin
            if (step_ff == load_last) state_in = sbc_pkg::ST_EXP_GEN;
         end
         sbc_pkg::ST_EXP_GEN: begin
            if (step_ff == gen_last) state_in = sbc_pkg::ST_IDLE;
         end
         sbc_pkg::ST_BLK_RUN: begin
            if (blk_last) state_in = sbc_pkg::ST_IDLE;
         end
         default: state_in = sbc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      step_in        = step_ff;
      round_count_in = round_count_ff;
      keyed_in       = keyed_ff;
      blk_in         = blk_ff;
      rsp_load       = 1'b0;
      rsp_in         = rsp_ff;
      uk_wr          = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_row     = req_data.word_index[ROW_W+1:2];
      ram_wr_mask    = 4'b0001 << req_data.word_index[1:0];
      ram_wr_data    = {4{req_data.key_word}};
      ram_rd_row     = mode_ff ? '0 : round_count_ff[ROW_W-1:0];
      rctrl          = '{op: sbc_pkg::OP_MIX, sbox_sel: 3'd0, skip_lin: 1'b0};
      ru_in          = blk_ff;
      wctrl          = '{clear: 1'b0, load: 1'b0, gen: 1'b0, wide: wide};

      unique case (state_ff)
         sbc_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_in = '{result_low: 64'd0, result_high: 64'd0,
                          status: sbc_pkg::STATUS_OK};
               step_in = 8'd0;
               unique case (req_data.cmd)
                  sbc_pkg::CMD_WRITE_KEY: begin
                     rsp_load = 1'b1;
                     if (req_data.word_index < 9'(KEY_WORDS)) begin
                        uk_wr = 1'b1;
                     end else begin
                        rsp_in.status = sbc_pkg::STATUS_BAD;
                     end
                  end
                  sbc_pkg::CMD_EXPAND: begin
                     if (exp_ok) begin
                        wctrl.clear = 1'b1;
                     end else begin
                        rsp_load = 1'b1;
                        rsp_in.status = sbc_pkg::STATUS_BAD;
                     end
                  end
                  sbc_pkg::CMD_WRITE_RK: begin
                     rsp_load = 1'b1;
                     if (req_data.word_index < 9'(MAX_ROUND_KEY_WORDS) && rk_cfg_ok) begin
                        ram_wr_en      = 1'b1;
                        round_count_in = loaded_rounds_ff;
                        keyed_in       = 1'b1;
                     end else begin
                        rsp_in.status = sbc_pkg::STATUS_BAD;
                     end
                  end
                  sbc_pkg::CMD_BLOCK: begin
                     if (keyed_ff) begin
                        blk_in = {req_data.block_high, req_data.block_low};
                     end else begin
                        rsp_load = 1'b1;
                        rsp_in.status = sbc_pkg::STATUS_UNKEYED;
                     end
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end

         sbc_pkg::ST_EXP_LOAD: begin
            wctrl.load = 1'b1;
            step_in = (step_ff == load_last) ? 8'd0 : next_step;
         end

         sbc_pkg::ST_EXP_GEN: begin
            // every fourth word closes a group, which goes through s-box (3 - group) mod 8
            wctrl.gen      = 1'b1;
            rctrl.op       = sbc_pkg::OP_SBOX;
            rctrl.sbox_sel = 3'd3 - step_ff[4:2];
            ru_in          = win_group;
            ram_wr_en      = (step_ff[1:0] == 2'd3);
            ram_wr_row     = ROW_W'(step_ff[7:2]);
            ram_wr_mask    = 4'b1111;
            ram_wr_data    = ru_out;
            step_in        = next_step;
            if (step_ff == gen_last) begin
               round_count_in = wide ? 7'd40 : 7'd32;
               keyed_in       = 1'b1;
               rsp_load       = 1'b1;
               rsp_in = '{result_low: 64'd0, result_high: 64'd0,
                          status: sbc_pkg::STATUS_OK};
            end
         end

         sbc_pkg::ST_BLK_RUN: begin
            if (mode_ff) begin
               rctrl.op       = blk_last ? sbc_pkg::OP_MIX : sbc_pkg::OP_ENC;
               rctrl.sbox_sel = step_ff[2:0];
               rctrl.skip_lin = (next_step == {1'b0, round_count_ff});
               ram_rd_row     = next_step[ROW_W-1:0];
            end else begin
               rctrl.op       = (step_ff == 8'd0) ? sbc_pkg::OP_MIX : sbc_pkg::OP_DEC;
               rctrl.sbox_sel = rev_step[2:0];
               rctrl.skip_lin = (rev_step == 8'd0);
               ram_rd_row     = rev_next[ROW_W-1:0];
            end
            blk_in  = ru_out;
            step_in = next_step;
            if (blk_last) begin
               rsp_load = 1'b1;
               rsp_in = '{result_low: ru_out[63:0], result_high: ru_out[127:64],
                          status: sbc_pkg::STATUS_OK};
            end
         end

         default: begin
            step_in = 8'd0;
         end
      endcase
   end

   // result register: loaded only when empty or draining
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sbc_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         keyed_ff       <= 1'b0;
         round_count_ff <= 7'd32;
         mode_ff        <= 1'b1;
         key_bytes_ff   <= 7'd32;
         loaded_rounds_ff <= 7'd40;
         for (int k = 0; k < KEY_WORDS; k++) user_key_ff[k] <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         keyed_ff       <= keyed_in;
         round_count_ff <= round_count_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               sbc_pkg::CSR_ENCRYPT_MODE:  mode_ff          <= csr_data[0];
               sbc_pkg::CSR_KEY_BYTES:     key_bytes_ff     <= csr_data;
               sbc_pkg::CSR_LOADED_ROUNDS: loaded_rounds_ff <= csr_data;
               default: ;
            endcase
         end
         if (uk_wr) begin
            user_key_ff[req_data.word_index[UK_W-1:0]] <= req_data.key_word;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      blk_ff  <= blk_in;
      rsp_ff  <= rsp_in;
   end

   sbc_round_unit u_round (
      .ctrl      (rctrl),
      .state_in  (ru_in),
      .round_key (ram_rd_data),
      .state_out (ru_out)
   );

   sbc_rk_ram #(
      .ROWS (ROWS)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_row  (ram_wr_row),
      .wr_mask (ram_wr_mask),
      .wr_data (ram_wr_data),
      .rd_row  (ram_rd_row),
      .rd_data (ram_rd_data)
   );

   sbc_key_window u_key_window (
      .clock     (clock),
      .ctrl      (wctrl),
      .load_word (ext_word),
      .gen_index (step_ff),
      .group     (win_group)
   );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the serpent block cipher unit with its own cipher predictor
`timescale 1ns / 1ps

module tb_top;

   localparam int  RK_WORDS   = 260;
   localparam int  UK_WORDS   = 16;
   localparam int  CYCLE_CAP  = 3000000;
   localparam int  ITEM_GOAL  = 1750;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   sbc_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   sbc_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_data = '0;

   serpent_block_cipher_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor state
   logic        cip_encrypt;
   logic [6:0]  cip_key_len;
   logic [6:0]  cip_load_rounds;
   logic [31:0] cip_user_key [UK_WORDS];
   logic [31:0] cip_round_key [RK_WORDS];
   logic [6:0]  cip_rounds;
   logic        cip_keyed;

   sbc_pkg::req_type pending_cmds[$];
   sbc_pkg::rsp_type expected_rsp[$];
   int      fail_count = 0;
   int      cycle_count = 0;
   int      items_built = 0;

   // state seen by the stimulus builder, so that no block reads an unwritten round key
   logic       bld_keyed;
   logic [6:0] bld_rounds;
   logic [6:0] bld_key_len;
   logic [6:0] bld_load_rounds;
   logic       bld_written [RK_WORDS];

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      logic [31:0] r;
      r = (n % 32 == 0) ? x : ((x << (n % 32)) | (x >> (32 - n % 32)));
      return r;
   endfunction

   // one s-box over the 32 bit columns; the inverse is found by search
   function automatic logic [127:0] column_sbox(input logic [127:0] x, input int sel,
                                                input logic inv);
      logic [127:0] y;
      logic [3:0]   nib;
      logic [3:0]   o;
      y = '0;
      for (int j = 0; j < 32; j++) begin
         nib = {x[96+j], x[64+j], x[32+j], x[j]};
         o = '0;
         if (inv) begin
            for (int k = 0; k < 16; k++)
               if (sbc_pkg::SBOX_FWD[sel][k] == nib) o = 4'(k);
         end else begin
            o = sbc_pkg::SBOX_FWD[sel][nib];
         end
         y[j] = o[0]; y[32+j] = o[1]; y[64+j] = o[2]; y[96+j] = o[3];
      end
      return y;
   endfunction

   function automatic logic [127:0] mix_layer(input logic [127:0] x, input logic inv);
      logic [31:0] w0, w1, w2, w3;
      {w3, w2, w1, w0} = x;
      if (!inv) begin
         w0 = rol(w0, 13); w2 = rol(w2, 3);
         w1 = w1 ^ w0 ^ w2; w3 = w3 ^ w2 ^ (w0 << 3);
         w1 = rol(w1, 1); w3 = rol(w3, 7);
         w0 = w0 ^ w1 ^ w3; w2 = w2 ^ w3 ^ (w1 << 7);
         w0 = rol(w0, 5); w2 = rol(w2, 22);
      end else begin
         w2 = rol(w2, 32 - 22); w0 = rol(w0, 32 - 5);
         w2 = w2 ^ w3 ^ (w1 << 7); w0 = w0 ^ w1 ^ w3;
         w3 = rol(w3, 32 - 7); w1 = rol(w1, 32 - 1);
         w3 = w3 ^ w2 ^ (w0 << 3); w1 = w1 ^ w0 ^ w2;
         w2 = rol(w2, 32 - 3); w0 = rol(w0, 32 - 13);
      end
      return {w3, w2, w1, w0};
   endfunction

   function automatic logic [127:0] round_key_row(input int r);
      return {cip_round_key[4*r+3], cip_round_key[4*r+2], cip_round_key[4*r+1],
              cip_round_key[4*r]};
   endfunction

   function automatic logic key_len_ok(input logic [6:0] n);
      return n == 16 || n == 24 || n == 32 || n == 64;
   endfunction

   function automatic logic load_rounds_ok(input logic [6:0] n);
      return n >= 32 && n <= 64 && n[2:0] == 3'd0;
   endfunction

   // key schedule: phi recurrence then s-boxes on each group of four words
   task automatic expand_schedule();
      logic [31:0] ext [UK_WORDS + RK_WORDS];
      logic [31:0] v;
      logic [127:0] row;
      int nw, taps, rounds, p;
      nw = cip_key_len / 4;
      rounds = (cip_key_len == 64) ? 40 : 32;
      taps = (cip_key_len == 64) ? 16 : 8;
      foreach (ext[i]) ext[i] = '0;
      for (int k = 0; k < nw; k++) ext[k] = cip_user_key[nw - 1 - k];
      if (nw < 8) ext[nw] = 32'd1;
      for (int i = 0; i < 4 * (rounds + 1); i++) begin
         p = taps + i;
         v = ext[p-8] ^ ext[p-5] ^ ext[p-3] ^ ext[p-1] ^ sbc_pkg::GOLDEN ^ 32'(i);
         if (taps == 16) v = v ^ ext[p-16] ^ ext[p-13] ^ ext[p-11] ^ ext[p-10];
         ext[p] = rol(v, sbc_pkg::KEY_ROT);
      end
      for (int i = 0; i <= rounds; i++) begin
         row = column_sbox({ext[taps+4*i+3], ext[taps+4*i+2], ext[taps+4*i+1],
                            ext[taps+4*i]}, (11 - (i % 8)) % 8, 1'b0);
         for (int k = 0; k < 4; k++) cip_round_key[4*i+k] = row[32*k +: 32];
      end
      cip_rounds = 7'(rounds);
      cip_keyed = 1'b1;
   endtask

   function automatic logic [127:0] run_cipher(input logic [127:0] blk);
      logic [127:0] x;
      int r;
      x = blk;
      r = cip_rounds;
      if (cip_encrypt) begin
         for (int i = 0; i < r; i++) begin
            x = column_sbox(x ^ round_key_row(i), i % 8, 1'b0);
            if (i + 1 != r) x = mix_layer(x, 1'b0);
         end
         x = x ^ round_key_row(r);
      end else begin
         x = x ^ round_key_row(r);
         for (int i = r; i > 0; i--) begin
            x = column_sbox(x, (i - 1) % 8, 1'b1) ^ round_key_row(i - 1);
            if (i != 1) x = mix_layer(x, 1'b1);
         end
      end
      return x;
   endfunction

   task automatic predict_command(input sbc_pkg::req_type c);
      sbc_pkg::rsp_type e;
      logic [127:0] out;
      e = '0;
      e.status = sbc_pkg::STATUS_OK;
      case (c.cmd)
         sbc_pkg::CMD_WRITE_KEY: begin
            if (c.word_index < UK_WORDS) cip_user_key[c.word_index] = c.key_word;
            else e.status = sbc_pkg::STATUS_BAD;
         end
         sbc_pkg::CMD_EXPAND: begin
            if (key_len_ok(cip_key_len)) expand_schedule();
            else e.status = sbc_pkg::STATUS_BAD;
         end
         sbc_pkg::CMD_WRITE_RK: begin
            if (c.word_index >= RK_WORDS || !load_rounds_ok(cip_load_rounds)) begin
               e.status = sbc_pkg::STATUS_BAD;
            end else begin
               cip_round_key[c.word_index] = c.key_word;
               cip_rounds = cip_load_rounds;
               cip_keyed = 1'b1;
            end
         end
         default: begin
            if (!cip_keyed) begin
               e.status = sbc_pkg::STATUS_UNKEYED;
            end else begin
               out = run_cipher({c.block_high, c.block_low});
               e.result_low = out[63:0];
               e.result_high = out[127:64];
            end
         end
      endcase
      expected_rsp = {expected_rsp, e};
   endtask

   // ---------------------------------------------------------------- idle patterns
   logic calm = 1'b0;

   function automatic int draw_gap();
      int r;
      if ($urandom_range(0, 40) == 0) calm = ~calm;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // ---------------------------------------------------------------- driver
   logic req_fired = 1'b0;
   int   req_gap = 0;
   int   rsp_stall = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_fired) begin
            // beat still waiting, hold it
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            req_data <= pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_gap = draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
         req_fired = 1'b0;
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = draw_gap();
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      sbc_pkg::rsp_type e;
      cycle_count++;
      if (cycle_count >= CYCLE_CAP) begin
         $display("%0t timeout with %0d results outstanding", $time, expected_rsp.size());
         $display("tb_top NOT OK");
         $finish;
      end else if (reset) begin
         cip_encrypt = 1'b1;
         cip_key_len = 7'd32;
         cip_load_rounds = 7'd40;
         foreach (cip_user_key[i]) cip_user_key[i] = '0;
         foreach (cip_round_key[i]) cip_round_key[i] = '0;
         cip_rounds = 7'd32;
         cip_keyed = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sbc_pkg::CSR_ENCRYPT_MODE:  cip_encrypt = csr_data[0];
               sbc_pkg::CSR_KEY_BYTES:     cip_key_len = csr_data;
               sbc_pkg::CSR_LOADED_ROUNDS: cip_load_rounds = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            req_fired = 1'b1;
            predict_command(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t unexpected result: actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.result_low !== e.result_low) begin
                  $display("%0t result_low: expected %h actual %h", $time,
                           e.result_low, rsp_data.result_low);
                  fail_count++;
               end
               if (rsp_data.result_high !== e.result_high) begin
                  $display("%0t result_high: expected %h actual %h", $time,
                           e.result_high, rsp_data.result_high);
                  fail_count++;
               end
               if (rsp_data.status !== e.status) begin
                  $display("%0t status: expected %0d actual %0d", $time,
                           e.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus builder
   task automatic queue_cmd(input logic [1:0] c, input logic [8:0] idx, input logic [31:0] w,
                            input logic [63:0] lo, input logic [63:0] hi);
      sbc_pkg::req_type t;
      t.cmd = c; t.word_index = idx; t.key_word = w; t.block_low = lo; t.block_high = hi;
      pending_cmds = {pending_cmds, t};
      items_built++;
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic add_key_word(input logic [8:0] idx, input logic [31:0] w);
      queue_cmd(sbc_pkg::CMD_WRITE_KEY, idx, w, rnd64(), rnd64());
   endtask

   task automatic add_expand();
      int r;
      if (key_len_ok(bld_key_len)) begin
         r = (bld_key_len == 64) ? 40 : 32;
         for (int i = 0; i < 4 * (r + 1); i++) bld_written[i] = 1'b1;
         bld_rounds = 7'(r);
         bld_keyed = 1'b1;
      end
      queue_cmd(sbc_pkg::CMD_EXPAND, 9'($urandom()), $urandom(), rnd64(), rnd64());
   endtask

   task automatic add_round_key(input logic [8:0] idx, input logic [31:0] w);
      if (idx < RK_WORDS && load_rounds_ok(bld_load_rounds)) begin
         bld_written[idx] = 1'b1;
         bld_rounds = bld_load_rounds;
         bld_keyed = 1'b1;
      end
      queue_cmd(sbc_pkg::CMD_WRITE_RK, idx, w, rnd64(), rnd64());
   endtask

   // a block that would touch a never written round key is left out
   task automatic add_block(input logic [63:0] lo, input logic [63:0] hi);
      logic ok;
      ok = 1'b1;
      if (bld_keyed)
         for (int i = 0; i < 4 * (bld_rounds + 1); i++)
            if (!bld_written[i]) ok = 1'b0;
      if (ok) queue_cmd(sbc_pkg::CMD_BLOCK, 9'($urandom()), $urandom(), lo, hi);
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         sbc_pkg::CSR_KEY_BYTES:     bld_key_len = val;
         sbc_pkg::CSR_LOADED_ROUNDS: bld_load_rounds = val;
         default: ;
      endcase
   endtask

   task automatic random_blocks(input int n);
      for (int i = 0; i < n; i++) add_block(rnd64(), rnd64());
   endtask

   // a full set of round keys for the present loaded_rounds
   task automatic load_round_keys();
      int n;
      n = 4 * (bld_load_rounds + 1);
      for (int i = 0; i < n; i++) add_round_key(9'(i), $urandom());
   endtask

   task automatic noise(input int n);
      logic [1:0] c;
      logic [8:0] idx;
      for (int i = 0; i < n; i++) begin
         c = 2'($urandom());
         idx = ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 20));
         case (c)
            sbc_pkg::CMD_WRITE_KEY: add_key_word(idx, $urandom());
            sbc_pkg::CMD_EXPAND:    add_expand();
            sbc_pkg::CMD_WRITE_RK:  add_round_key(idx, $urandom());
            default:                add_block(rnd64(), rnd64());
         endcase
      end
   endtask

   initial begin
      logic [6:0] kl;
      logic [6:0] lr;
      int kind;
      bld_keyed = 1'b0;
      bld_rounds = 7'd32;
      bld_key_len = 7'd32;
      bld_load_rounds = 7'd40;
      foreach (bld_written[i]) bld_written[i] = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unkeyed block, bad key indexes, 256-bit key with extreme words, bad round key indexes
      add_block('0, '1);
      add_key_word(9'd16, '1);
      add_key_word(9'h1FF, '1);
      for (int i = 0; i < 8; i++) add_key_word(9'(i), (i % 2) ? 32'hFFFF_FFFF : 32'h0);
      add_expand();
      add_block('0, '0);
      add_block('1, '1);
      add_round_key(9'd260, 32'h1234_5678);
      add_round_key(9'h1FF, 32'h1234_5678);
      wait_idle();

      // short keys, the widest key, rejected lengths and rejected round counts, decrypting
      write_reg(sbc_pkg::CSR_ENCRYPT_MODE, 7'd0);
      write_reg(sbc_pkg::CSR_KEY_BYTES, 7'd16);
      add_expand();
      add_block('1, '0);
      wait_idle();
      write_reg(sbc_pkg::CSR_KEY_BYTES, 7'd24);
      add_expand();
      add_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      wait_idle();
      write_reg(sbc_pkg::CSR_KEY_BYTES, 7'd64);
      for (int i = 8; i < 16; i++) add_key_word(9'(i), '1);
      add_expand();
      add_block('0, '1);
      wait_idle();
      write_reg(sbc_pkg::CSR_KEY_BYTES, 7'd0);
      add_expand();
      wait_idle();
      write_reg(sbc_pkg::CSR_KEY_BYTES, 7'd127);
      write_reg(sbc_pkg::CSR_LOADED_ROUNDS, 7'd31);
      add_expand();
      add_round_key(9'd0, '1);
      wait_idle();
      write_reg(sbc_pkg::CSR_LOADED_ROUNDS, 7'd33);
      add_round_key(9'd0, '1);
      wait_idle();
      write_reg(sbc_pkg::CSR_LOADED_ROUNDS, 7'd72);
      add_round_key(9'd0, '1);
      wait_idle();

      // random phases: each one a setting and a well formed sequence, some with noise mixed in, or noise alone
      while (items_built < ITEM_GOAL) begin
         write_reg(sbc_pkg::CSR_ENCRYPT_MODE, 7'($urandom_range(0, 1)));
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            case ($urandom_range(0, 9))
               0, 1, 2: kl = 7'd16;
               3, 4:    kl = 7'd24;
               5, 6:    kl = 7'd32;
               7, 8:    kl = 7'd64;
               default: kl = 7'($urandom());
            endcase
            write_reg(sbc_pkg::CSR_KEY_BYTES, kl);
            for (int i = 0; i < kl / 4 && i < UK_WORDS; i++) add_key_word(9'(i), $urandom());
            if ($urandom_range(0, 4) == 0) noise(3);
            add_expand();
            random_blocks($urandom_range(4, 14));
         end else if (kind < 8) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: lr = 7'd32;
               5, 6:          lr = 7'd40;
               7:             lr = 7'd48 + 7'(8 * $urandom_range(0, 1));
               8:             lr = 7'd64;
               default:       lr = 7'($urandom());
            endcase
            write_reg(sbc_pkg::CSR_LOADED_ROUNDS, lr);
            load_round_keys();
            random_blocks($urandom_range(6, 20));
         end else begin
            noise($urandom_range(10, 30));
         end
         wait_idle();
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

endmodule
